// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands used by the checker file b64enc_checker.sv
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on clk_i, off while rst_ni is low
`define B64_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// signal keeps its value in the cycle after cond
`define B64_ASSERT_HOLD(label, cond, sig, msg) \
  `B64_ASSERT(label, (cond) |=> $stable(sig), msg)

`endif

// File: hw/rtl/b64enc_pkg.sv
// ----------------------------------------------------------------------------
// b64enc_pkg
// types, constants and the sextet alphabet of the base64 stream encoder
// ----------------------------------------------------------------------------
`default_nettype none

package b64enc_pkg;

  localparam int QueueDepth = 4;

  localparam logic [6:0] PadChar   = 7'd61;  // '='
  localparam logic [6:0] UpperBase = 7'd65;  // 'A'
  localparam logic [6:0] LowerOffs = 7'd71;  // 'a' minus 26
  localparam logic [6:0] DigitOffs = 7'd4;   // 52 minus '0'
  localparam logic [6:0] PlusChar  = 7'd43;  // '+'
  localparam logic [6:0] SlashChar = 7'd47;  // '/'

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_e;

  // one byte worth of characters, cnt_m1 is the count less one
  typedef struct packed {
    logic [3:0][6:0] chars;
    logic [1:0]      cnt_m1;
    logic            last;
  } job_t;

  function automatic logic [6:0] sextet_char(input logic [5:0] v);
    logic [6:0] c;
    if (v < 6'd26) begin
      c = UpperBase + {1'b0, v};
    end else if (v < 6'd52) begin
      c = LowerOffs + {1'b0, v};
    end else if (v < 6'd62) begin
      c = {1'b0, v} - DigitOffs;
    end else if (v == 6'd62) begin
      c = PlusChar;
    end else begin
      c = SlashChar;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/b64enc_byte_if.sv
// ----------------------------------------------------------------------------
// b64enc_byte_if
// valid/ready channel carrying message bytes
// ----------------------------------------------------------------------------
`default_nettype none

interface b64enc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/b64enc_char_if.sv
// ----------------------------------------------------------------------------
// b64enc_char_if
// valid/ready channel carrying encoded characters
// ----------------------------------------------------------------------------
`default_nettype none

interface b64enc_char_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       last_char;

  modport source (output valid, output out_char, output last_char, input ready);
  modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/base64_stream_encoder_unit.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder_unit
// base64 encoder with '=' padding, message bytes in, characters out
//
// byte_i takes message bytes, end_of_message set on the final byte of each
// message. char_o gives ASCII characters, last_char set on the final one.
// a transfer happens on a clock edge with valid and ready both high.
// a transferred byte is written as a job into the queue; the back side then
// loads its characters into the output register. the output register sends
// one character per cycle while char_o.ready is high; a middle byte gives 1
// or 2 characters and a final byte 2, 3 or 4. bytes enter at one per cycle
// while the job queue has room, even while earlier bytes' characters go out.
// over a long message the single-character output register sets the rate.
// reset clears the group position, the queue and the output valid flag; no
// message state survives it.
// when the receiver stalls, the character holds on char_o, the queue fills
// and then byte_i.ready drops until the back side drains a job.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_stream_encoder_unit #(
  parameter int QUEUE_DEPTH = b64enc_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  b64enc_byte_if.sink   byte_i,
  b64enc_char_if.source char_o
);
  import b64enc_pkg::*;

  job_t front_job, head_job;
  logic front_valid, front_ready;
  logic head_valid, head_pop;

  b64enc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_i      (byte_i),
    .job_o       (front_job),
    .job_valid_o (front_valid),
    .job_ready_i (front_ready)
  );

  b64enc_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_job_i   (front_job),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .head_o       (head_job),
    .head_valid_o (head_valid),
    .pop_i        (head_pop)
  );

  b64enc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_job),
    .head_valid_i (head_valid),
    .pop_o        (head_pop),
    .char_o       (char_o)
  );

endmodule

`default_nettype wire

// File: hw/rtl/b64enc_front.sv
// ----------------------------------------------------------------------------
// b64enc_front
// accepts bytes, tracks the group position and builds character jobs
// ----------------------------------------------------------------------------
`default_nettype none

module b64enc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  b64enc_byte_if.sink       byte_i,
  output b64enc_pkg::job_t  job_o,
  output logic              job_valid_o,
  input  logic              job_ready_i
);
  import b64enc_pkg::*;

  phase_e     phase_q, phase_d;
  logic [3:0] left_q, left_d;
  logic       xfer;
  logic [7:0] b;
  logic       eom;

  assign byte_i.ready = job_ready_i;
  assign job_valid_o  = byte_i.valid;
  assign xfer         = byte_i.valid && job_ready_i;
  assign b            = byte_i.data_byte;
  assign eom          = byte_i.end_of_message;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIRST;
      left_q  <= '0;
    end else if (xfer) begin
      phase_q <= phase_d;
      left_q  <= left_d;
    end
  end

  always_comb begin
    job_o.chars  = {PadChar, PadChar, PadChar, PadChar};
    job_o.last   = eom;
    job_o.cnt_m1 = 2'd0;
    phase_d      = PH_FIRST;
    left_d       = '0;
    case (phase_q)
      PH_SECOND: begin
        job_o.chars[0] = sextet_char({left_q[1:0], b[7:4]});
        if (eom) begin
          job_o.chars[1] = sextet_char({b[3:0], 2'b00});
          job_o.cnt_m1   = 2'd2;
        end else begin
          phase_d = PH_THIRD;
          left_d  = b[3:0];
        end
      end
      PH_THIRD: begin
        job_o.chars[0] = sextet_char({left_q, b[7:6]});
        job_o.chars[1] = sextet_char(b[5:0]);
        job_o.cnt_m1   = 2'd1;
      end
      default: begin
        job_o.chars[0] = sextet_char(b[7:2]);
        if (eom) begin
          job_o.chars[1] = sextet_char({b[1:0], 4'b0000});
          job_o.cnt_m1   = 2'd3;
        end else begin
          phase_d = PH_SECOND;
          left_d  = {2'b00, b[1:0]};
        end
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/b64enc_queue.sv
// ----------------------------------------------------------------------------
// b64enc_queue
// small job queue between the byte front and the character back
// ----------------------------------------------------------------------------
`default_nettype none

module b64enc_queue #(
  parameter int Depth = b64enc_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  b64enc_pkg::job_t  push_job_i,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  output b64enc_pkg::job_t  head_o,
  output logic              head_valid_o,
  input  logic              pop_i
);
  import b64enc_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop, full, empty;

  assign full         = (cnt_q == CntW'(Depth));
  assign empty        = (cnt_q == '0);
  assign push_ready_o = !full;
  assign head_valid_o = !empty;
  assign head_o       = mem_q[rd_ptr_q];
  assign push         = push_valid_i && !full;
  assign pop          = pop_i && !empty;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/b64enc_back.sv
// ----------------------------------------------------------------------------
// b64enc_back
// steps through the characters of the head job into the output register
// ----------------------------------------------------------------------------
`default_nettype none

module b64enc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  b64enc_pkg::job_t  head_i,
  input  logic              head_valid_i,
  output logic              pop_o,
  b64enc_char_if.source     char_o
);
  import b64enc_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  logic [6:0] char_q;
  logic       last_q;
  logic       slot_free, load, at_end;

  assign slot_free = !valid_q || char_o.ready;
  assign load      = head_valid_i && slot_free;
  assign at_end    = (idx_q == head_i.cnt_m1);
  assign pop_o     = load && at_end;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q && !char_o.ready;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = at_end ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= head_i.chars[idx_q];
      last_q <= head_i.last && at_end;
    end
  end

  assign char_o.valid     = valid_q;
  assign char_o.out_char  = char_q;
  assign char_o.last_char = last_q;

endmodule

`default_nettype wire

// File: hw/rtl/b64enc_checker.sv
// ----------------------------------------------------------------------------
// b64enc_checker
// port-level checks of the encoder output, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module b64enc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [6:0] out_char_i,
  input logic       last_char_i
);
  import b64enc_pkg::*;

  logic stall, pad_xfer, last_pad;
  logic is_upper, is_lower, is_digit, in_alphabet;

  assign stall       = out_valid_i && !out_ready_i;
  assign pad_xfer    = out_valid_i && out_ready_i && !last_char_i && (out_char_i == PadChar);
  assign last_pad    = out_valid_i && last_char_i && (out_char_i == PadChar);
  assign is_upper    = (out_char_i >= 7'd65) && (out_char_i <= 7'd90);
  assign is_lower    = (out_char_i >= 7'd97) && (out_char_i <= 7'd122);
  assign is_digit    = (out_char_i >= 7'd48) && (out_char_i <= 7'd57);
  assign in_alphabet = is_upper || is_lower || is_digit || (out_char_i == PlusChar) ||
                       (out_char_i == SlashChar) || (out_char_i == PadChar);

  `B64_ASSERT(a_valid_held, stall |=> out_valid_i, "char valid dropped while stalled")
  `B64_ASSERT_HOLD(a_char_held, stall, out_char_i, "char changed while stalled")
  `B64_ASSERT(a_double_pad, pad_xfer |=> last_pad, "first pad not followed by final pad")
  `B64_ASSERT(a_alphabet, out_valid_i |-> in_alphabet, "char outside base64 alphabet")

endmodule

bind base64_stream_encoder_unit b64enc_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (char_o.valid),
  .out_ready_i (char_o.ready),
  .out_char_i  (char_o.out_char),
  .last_char_i (char_o.last_char)
);

`default_nettype wire

// File: tb/base64_stream_encoder_unit_tb.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder_unit_tb
// self-checking testbench for the base64 stream encoder
//
// messages go in one byte per transfer, the last byte flagged. a predictor
// tracks the group position and the leftover bits, and queues the characters
// each accepted byte must produce. every character transfer is checked
// against the oldest queued one. directed messages cover each group position
// for the final byte and the alphabet ends, random messages run under
// several sender idle and receiver stall mixes, and one test holds the
// receiver off long enough to fill the block and stall its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module base64_stream_encoder_unit_tb;
  import b64enc_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 20;

  localparam logic [0:63][7:0] B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct {
    logic [6:0] ch;
    logic       is_last;
  } char_rec_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  b64enc_byte_if byte_bus ();
  b64enc_char_if char_bus ();

  base64_stream_encoder_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_bus),
    .char_o (char_bus)
  );

  char_rec_t   expected_chars[$];
  phase_e      enc_phase = PH_FIRST;
  logic [3:0]  enc_rest  = 4'd0;
  int          fail_count = 0;
  int          sender_idle_pct = 0;
  int          receiver_stall_pct = 0;
  int          hold_off_left = 0;
  int          quiet_cycles = 0;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // encoder predictor
  function automatic void push_char(input logic [6:0] c);
    char_rec_t r;
    r.ch      = c;
    r.is_last = 1'b0;
    expected_chars.push_back(r);
  endfunction

  function automatic logic [6:0] sextet_to_ascii(input logic [5:0] v);
    return B64_ALPHABET[v][6:0];
  endfunction

  function automatic void encode_byte(input logic [7:0] b, input logic eom);
    case (enc_phase)
      PH_SECOND: begin
        push_char(sextet_to_ascii({enc_rest[1:0], b[7:4]}));
        enc_rest  = b[3:0];
        enc_phase = PH_THIRD;
        if (eom) begin
          push_char(sextet_to_ascii({b[3:0], 2'b00}));
          push_char(PadChar);
        end
      end
      PH_THIRD: begin
        push_char(sextet_to_ascii({enc_rest, b[7:6]}));
        push_char(sextet_to_ascii(b[5:0]));
        enc_rest  = 4'd0;
        enc_phase = PH_FIRST;
      end
      default: begin
        push_char(sextet_to_ascii(b[7:2]));
        enc_rest  = {2'b00, b[1:0]};
        enc_phase = PH_SECOND;
        if (eom) begin
          push_char(sextet_to_ascii({b[1:0], 4'b0000}));
          push_char(PadChar);
          push_char(PadChar);
        end
      end
    endcase
    if (eom) begin
      expected_chars[expected_chars.size() - 1].is_last = 1'b1;
      enc_phase = PH_FIRST;
      enc_rest  = 4'd0;
    end
  endfunction

  // receiver side, long hold-off counted here
  initial begin
    char_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_left > 0) begin
        hold_off_left--;
        char_bus.ready <= 1'b0;
      end else begin
        char_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  // character checker
  always @(posedge clk_i) begin : check_chars
    char_rec_t exp_rec;
    if (rst_ni && char_bus.valid && char_bus.ready) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected character transfer: out_char %0d last_char %0b",
               char_bus.out_char, char_bus.last_char);
        fail_count++;
      end else begin
        exp_rec = expected_chars.pop_front();
        if (char_bus.out_char !== exp_rec.ch) begin
          $error("out_char mismatch: expected %0d actual %0d",
                 exp_rec.ch, char_bus.out_char);
          fail_count++;
        end
        if (char_bus.last_char !== exp_rec.is_last) begin
          $error("last_char mismatch: expected %0b actual %0b",
                 exp_rec.is_last, char_bus.last_char);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((byte_bus.valid && byte_bus.ready) || (char_bus.valid && char_bus.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles + 1 >= WatchdogLimit) begin
          $error("no transfer for %0d cycles", WatchdogLimit);
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] data, input logic eom);
    while ($urandom_range(99) < sender_idle_pct) begin
      byte_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_bus.valid          <= 1'b1;
    byte_bus.data_byte      <= data;
    byte_bus.end_of_message <= eom;
    @(posedge clk_i);
    while (!byte_bus.ready) @(posedge clk_i);
    encode_byte(data, eom);
  endtask

  task automatic send_message(input logic [7:0] msg[$]);
    foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
  endtask

  task automatic wait_drained();
    byte_bus.valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_random_messages(input int n_bytes);
    logic [7:0] msg[$];
    int         len;
    int         sent;
    sent = 0;
    while (sent < n_bytes) begin
      len = ($urandom_range(99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 40);
      msg = {};
      repeat (len) msg.push_back(8'($urandom_range(0, 255)));
      send_message(msg);
      sent += len;
    end
  endtask

  // final byte at each group position, alphabet ends, all-zero and all-one
  task automatic test_directed();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    send_message('{8'h00});
    send_message('{8'hFF});
    send_message('{8'h4D, 8'h61});
    send_message('{8'h4D, 8'h61, 8'h6E});
    send_message('{8'hFF, 8'hFF, 8'hFF, 8'hFF});
    send_message('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    send_message('{8'hFB, 8'hEF, 8'hBE});
    send_message('{8'hFF, 8'hFF, 8'hFF});
    wait_drained();
  endtask

  task automatic test_random_flow(input int idle_pct, input int stall_pct, input int n_bytes);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    send_random_messages(n_bytes);
    wait_drained();
  endtask

  // receiver held off while bytes keep coming, fills the block
  task automatic test_output_hold_off();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_off_left      = 300;
    send_random_messages(40);
    wait_drained();
  endtask

  initial begin
    rst_ni                  <= 1'b0;
    byte_bus.valid          <= 1'b0;
    byte_bus.data_byte      <= 8'h00;
    byte_bus.end_of_message <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_flow(0, 0, 110);
    test_random_flow(55, 0, 110);
    test_random_flow(0, 55, 110);
    test_random_flow(6, 6, 110);
    test_output_hold_off();

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_chars.size() != 0) begin
      $error("%0d characters never arrived", expected_chars.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
